>>> hdl/amtd_pkg.sv
// Package for the accelerometer motion and tilt detector.
// Request codes, register indexes and reset defaults. No dependencies.
`default_nettype none
package amtd_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int MAX_BASELINE_DEF = 1024;

    // request codes
    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_MONITOR = 2'd1;
    localparam logic [1:0] REQ_FAIL    = 2'd2;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] CFG_SENSOR  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_VIB_TH  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_TILT_COS = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BSAMP   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CONFIRM = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_MIN_MAG = 3'd5;

    // register reset values
    localparam logic [15:0]        DEF_VIB_TH   = 16'd418;
    localparam logic signed [15:0] DEF_TILT_COS = 16'sd32269;
    localparam logic [10:0]        DEF_BSAMP    = 11'd32;
    localparam logic [15:0]        DEF_CONFIRM  = 16'd500;
    localparam logic [11:0]        DEF_MIN_MAG  = 12'd42;

endpackage
`default_nettype wire

>>> hdl/amtd_sqrt.sv
// Iterative integer square root, one result bit per cycle, rounded to nearest.
// Standalone; used by accel_motion_tilt_detector_top.
`default_nettype none
module amtd_sqrt #(
    parameter int QW = 34,
    parameter int RW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [QW-1:0] i_rad,
    output logic               o_done,
    output logic [RW-1:0]      o_root
);

    logic [QW-1:0] r_n, r_r, r_bit;
    logic          r_busy, r_done;
    logic [RW-1:0] r_root;
    logic [QW-1:0] rb, n2, r2, rf;

    always_comb begin
        rb = r_r + r_bit;
        if (r_n >= rb) begin
            n2 = r_n - rb;
            r2 = (r_r >> 1) + r_bit;
        end else begin
            n2 = r_n;
            r2 = r_r >> 1;
        end
        rf = r2 + QW'(n2 > r2);   // round: remainder above root
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= i_rad;
                r_r    <= '0;
                r_bit  <= QW'(1) << (QW - 2);
            end else if (r_busy) begin
                r_n   <= n2;
                r_r   <= r2;
                r_bit <= r_bit >> 2;
                if (r_bit == QW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_root <= rf[RW-1:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

>>> hdl/accel_motion_tilt_detector_top.sv
// Accelerometer motion and tilt detector, top level.
// Control words and plain calibration samples go straight to the output stage;
// a motion sample passes the sum of squares, the serial square root and the tilt products;
// the closing calibration sample runs the divider on each axis, then the square root.
// One word in flight at a time; a finished word waits in the output register.
// Reset (sync, active low) restores register defaults and the baseline 0,0,1 g.
`default_nettype none
module accel_motion_tilt_detector_top #(
    parameter int SAMPLE_BITS  = amtd_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_BASELINE = amtd_pkg::MAX_BASELINE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [amtd_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  wire logic [amtd_pkg::CFG_DW-1:0]   i_cfg_data,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  wire logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  wire logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  wire logic [31:0]                   i_time_ms,
    input  wire logic                          i_monitor_enable,
    // output channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_motion_detected,
    output logic                               o_calibrating,
    output logic                               o_monitoring,
    output logic                               o_over_threshold,
    output logic [SAMPLE_BITS-1:0]             o_vibration,
    output logic                               o_tilt_over
);
    import amtd_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int CNT = $clog2(MAX_BASELINE + 1);   // sample counter
    localparam int SW  = SB + CNT;                    // axis sum
    localparam int DW  = SW + 1;                      // divider dividend
    localparam int DCW = $clog2(DW + 1);
    localparam int MW  = (SB + 1 > 17) ? SB + 1 : 17; // multiplier operand
    localparam int AW  = 2 * SB + 18;                 // accumulator
    localparam int QW  = 2 * SB + 2;                  // sum of squares
    localparam logic signed [SB-1:0] ONE_G = SB'(1) << (SB - 4);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ    = 4'd1;  // sum of squares
    localparam logic [3:0] ST_SQS   = 4'd2;  // start root
    localparam logic [3:0] ST_SQW   = 4'd3;  // wait root
    localparam logic [3:0] ST_DOT   = 4'd4;  // dot product
    localparam logic [3:0] ST_RHS1  = 4'd5;  // bmag * mag
    localparam logic [3:0] ST_RHS2  = 4'd6;  // cos * low half
    localparam logic [3:0] ST_RHS3  = 4'd7;  // cos * high half
    localparam logic [3:0] ST_EVAL  = 4'd8;
    localparam logic [3:0] ST_DLOAD = 4'd9;
    localparam logic [3:0] ST_DIV   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    // configuration registers
    logic               r_sensor;
    logic [15:0]        r_vib_th;
    logic signed [15:0] r_cos;
    logic [10:0]        r_bsamp;
    logic [15:0]        r_confirm;
    logic [11:0]        r_min_mag;

    // detector state
    logic                 r_mon, r_calib, r_exc, r_motion, r_tilt;
    logic [31:0]          r_since;
    logic [CNT-1:0]       r_cnt;
    logic signed [SW-1:0] r_sum [3];
    logic signed [SB-1:0] r_base [3];
    logic [SB-1:0]        r_bmag, r_vib;

    // working registers
    logic [3:0]           r_st;
    logic [1:0]           r_k;
    logic                 r_use_base;
    logic signed [SB-1:0] r_ax [3];
    logic [31:0]          r_time;
    logic signed [AW-1:0] r_acc, r_lhs;
    logic [2*SB-1:0]      r_prod;
    logic [SB-1:0]        r_mag;
    logic [DW-1:0]        r_q;
    logic [CNT-1:0]       r_rem;
    logic [DCW-1:0]       r_dcnt;
    logic                 r_neg;

    // output register
    logic          r_ov, r_o_motion, r_o_calib, r_o_mon, r_o_exc, r_o_tilt;
    logic [SB-1:0] r_o_vib;

    // shared multiplier
    logic signed [MW-1:0]   opa, opb;
    logic signed [2*MW-1:0] prod;
    logic signed [SB-1:0]   elem;

    always_comb begin
        elem = r_use_base ? r_base[r_k] : r_ax[r_k];
        opa  = '0;
        opb  = '0;
        case (r_st)
            ST_SQ: begin
                opa = MW'(elem);
                opb = MW'(elem);
            end
            ST_DOT: begin
                opa = MW'(r_base[r_k]);
                opb = MW'(r_ax[r_k]);
            end
            ST_RHS1: begin
                opa = MW'(r_bmag);
                opb = MW'(r_mag);
            end
            ST_RHS2: begin
                opa = MW'(r_cos);
                opb = MW'(r_prod[SB-1:0]);
            end
            ST_RHS3: begin
                opa = MW'(r_cos);
                opb = MW'(r_prod[2*SB-1:SB]);
            end
            default: ;
        endcase
        prod = opa * opb;
    end

    // square root unit
    logic          sq_start, sq_done;
    logic [SB-1:0] sq_root;

    assign sq_start = (r_st == ST_SQS);

    amtd_sqrt #(.QW(QW), .RW(SB)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_acc[QW-1:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // calibration target, clamped to 1..MAX_BASELINE
    logic [CNT-1:0] tgt, cnt1;
    always_comb begin
        if (r_bsamp == '0)
            tgt = CNT'(1);
        else if (32'(r_bsamp) > 32'(MAX_BASELINE))
            tgt = CNT'(MAX_BASELINE);
        else
            tgt = CNT'(r_bsamp);
        cnt1 = r_cnt + CNT'(1);
    end

    // divider step and dividend load
    logic signed [DW-1:0] s_ext;
    logic [DW-1:0]        dvd;
    logic [CNT:0]         dtrial;
    always_comb begin
        s_ext  = DW'(r_sum[r_k]);
        dvd    = (s_ext[DW-1] ? DW'(-s_ext) : DW'(s_ext)) + DW'(r_cnt >> 1);
        dtrial = {r_rem, r_q[DW-1]};
    end

    // motion evaluation
    logic [SB-1:0] vib;
    logic          tilt, exceeds;
    always_comb begin
        vib  = (r_mag >= r_bmag) ? r_mag - r_bmag : r_bmag - r_mag;
        tilt = (32'(r_bmag) >= 32'(r_min_mag)) && (32'(r_mag) >= 32'(r_min_mag))
               && (r_lhs <= r_acc);
        exceeds = (32'(vib) >= 32'(r_vib_th)) || tilt;
    end

    logic accept, out_free;
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;
    assign o_stall  = (r_st != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor  <= 1'b0;
            r_vib_th  <= DEF_VIB_TH;
            r_cos     <= DEF_TILT_COS;
            r_bsamp   <= DEF_BSAMP;
            r_confirm <= DEF_CONFIRM;
            r_min_mag <= DEF_MIN_MAG;
            r_mon     <= 1'b0;
            r_calib   <= 1'b0;
            r_exc     <= 1'b0;
            r_motion  <= 1'b0;
            r_tilt    <= 1'b0;
            r_since   <= '0;
            r_vib     <= '0;
            r_cnt     <= '0;
            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
            r_base[0] <= '0;
            r_base[1] <= '0;
            r_base[2] <= ONE_G;
            r_bmag    <= SB'(ONE_G);
            r_st      <= ST_IDLE;
            r_ov      <= 1'b0;
        end else begin
            // a new result takes the output register, else a taken one leaves it
            if (r_st == ST_DONE && out_free) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SENSOR: begin
                        r_sensor <= i_cfg_data[0];
                        r_mon    <= 1'b0;
                        r_calib  <= 1'b0;
                        r_motion <= 1'b0;
                        r_exc    <= 1'b0;
                        r_since  <= '0;
                        r_vib    <= '0;
                        r_tilt   <= 1'b0;
                    end
                    CFG_VIB_TH:   r_vib_th  <= i_cfg_data;
                    CFG_TILT_COS: r_cos     <= $signed(i_cfg_data);
                    CFG_BSAMP:    r_bsamp   <= i_cfg_data[10:0];
                    CFG_CONFIRM:  r_confirm <= i_cfg_data;
                    CFG_MIN_MAG:  r_min_mag <= i_cfg_data[11:0];
                    default: ;
                endcase
            end

            case (r_st)
                ST_IDLE: begin
                    if (accept) begin
                        r_st <= ST_DONE;
                        if (i_req_type == REQ_MONITOR) begin
                            if (!r_sensor || (i_monitor_enable != r_mon)) begin
                                if (!r_sensor) begin
                                    r_mon   <= 1'b0;
                                    r_calib <= 1'b0;
                                end else begin
                                    r_mon   <= i_monitor_enable;
                                    r_calib <= i_monitor_enable;
                                    if (i_monitor_enable) begin
                                        r_cnt <= '0;
                                        for (int i = 0; i < 3; i++) r_sum[i] <= '0;
                                    end
                                end
                                r_motion <= 1'b0;
                                r_exc    <= 1'b0;
                                r_since  <= '0;
                                r_vib    <= '0;
                                r_tilt   <= 1'b0;
                            end
                        end else if (r_sensor && r_mon) begin
                            if (i_req_type == REQ_FAIL) begin
                                r_motion <= 1'b0;
                                r_exc    <= 1'b0;
                                r_since  <= '0;
                                r_vib    <= '0;
                                r_tilt   <= 1'b0;
                            end else if (i_req_type == REQ_SAMPLE) begin
                                if (r_calib) begin
                                    r_sum[0] <= r_sum[0] + SW'(i_accel_x);
                                    r_sum[1] <= r_sum[1] + SW'(i_accel_y);
                                    r_sum[2] <= r_sum[2] + SW'(i_accel_z);
                                    r_cnt    <= cnt1;
                                    if (cnt1 >= tgt) begin
                                        r_k  <= 2'd0;
                                        r_st <= ST_DLOAD;
                                    end
                                end else begin
                                    r_ax[0]    <= i_accel_x;
                                    r_ax[1]    <= i_accel_y;
                                    r_ax[2]    <= i_accel_z;
                                    r_time     <= i_time_ms;
                                    r_acc      <= '0;
                                    r_k        <= 2'd0;
                                    r_use_base <= 1'b0;
                                    r_st       <= ST_SQ;
                                end
                            end
                        end
                    end
                end
                ST_SQ: begin
                    r_acc <= r_acc + AW'(prod);
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd2) r_st <= ST_SQS;
                end
                ST_SQS: r_st <= ST_SQW;
                ST_SQW: begin
                    if (sq_done) begin
                        if (r_use_base) begin
                            r_bmag   <= sq_root;
                            r_calib  <= 1'b0;
                            r_motion <= 1'b0;
                            r_exc    <= 1'b0;
                            r_since  <= '0;
                            r_vib    <= '0;
                            r_tilt   <= 1'b0;
                            r_st     <= ST_DONE;
                        end else begin
                            r_mag <= sq_root;
                            r_acc <= '0;
                            r_k   <= 2'd0;
                            r_st  <= ST_DOT;
                        end
                    end
                end
                ST_DOT: begin
                    r_acc <= r_acc + AW'(prod);
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd2) r_st <= ST_RHS1;
                end
                ST_RHS1: begin
                    r_lhs  <= r_acc <<< 15;     // dot * 32768
                    r_prod <= prod[2*SB-1:0];
                    r_st   <= ST_RHS2;
                end
                ST_RHS2: begin
                    r_acc <= AW'(prod);
                    r_st  <= ST_RHS3;
                end
                ST_RHS3: begin
                    r_acc <= r_acc + (AW'(prod) <<< SB);
                    r_st  <= ST_EVAL;
                end
                ST_EVAL: begin
                    r_vib  <= vib;
                    r_tilt <= tilt;
                    if (!exceeds) begin
                        r_exc    <= 1'b0;
                        r_since  <= '0;
                        r_motion <= 1'b0;
                    end else if (!r_exc) begin
                        r_exc    <= 1'b1;
                        r_since  <= r_time;
                        r_motion <= 1'b0;
                    end else begin
                        r_motion <= (r_time - r_since) >= 32'(r_confirm);
                    end
                    r_st <= ST_DONE;
                end
                ST_DLOAD: begin
                    r_neg  <= r_sum[r_k][SW-1];
                    r_q    <= dvd;
                    r_rem  <= '0;
                    r_dcnt <= DCW'(DW);
                    r_st   <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_dcnt == '0) begin
                        r_base[r_k] <= r_neg ? -SB'(r_q) : SB'(r_q);
                        if (r_k == 2'd2) begin
                            r_acc      <= '0;
                            r_k        <= 2'd0;
                            r_use_base <= 1'b1;
                            r_st       <= ST_SQ;
                        end else begin
                            r_k  <= r_k + 2'd1;
                            r_st <= ST_DLOAD;
                        end
                    end else begin
                        r_dcnt <= r_dcnt - DCW'(1);
                        if (dtrial >= {1'b0, r_cnt}) begin
                            r_rem <= CNT'(dtrial - {1'b0, r_cnt});
                            r_q   <= {r_q[DW-2:0], 1'b1};
                        end else begin
                            r_rem <= dtrial[CNT-1:0];
                            r_q   <= {r_q[DW-2:0], 1'b0};
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_o_motion <= r_motion;
                        r_o_calib  <= r_calib;
                        r_o_mon    <= r_mon;
                        r_o_exc    <= r_exc;
                        r_o_vib    <= r_vib;
                        r_o_tilt   <= r_tilt;
                        r_st       <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ov;
    assign o_motion_detected = r_o_motion;
    assign o_calibrating     = r_o_calib;
    assign o_monitoring      = r_o_mon;
    assign o_over_threshold  = r_o_exc;
    assign o_vibration       = r_o_vib;
    assign o_tilt_over       = r_o_tilt;

endmodule
`default_nettype wire
